// ----- hdl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg: shared definitions for the Mandelbrot escape-time core
// Register indexes, reset values, queue entry type, saturation helper.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LIMIT_BITS     = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_FRAC_BITS  = 22;
   localparam int DEF_COUNT_BITS = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_X_RE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_X_IM  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_Y_RE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_Y_IM  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_RE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_IM  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd6;

   // reset values
   localparam logic signed [DATA_BITS-1:0] RST_STEP_X_RE = 32'sd9175;
   localparam logic signed [DATA_BITS-1:0] RST_STEP_X_IM = 32'sd0;
   localparam logic signed [DATA_BITS-1:0] RST_STEP_Y_RE = 32'sd0;
   localparam logic signed [DATA_BITS-1:0] RST_STEP_Y_IM = 32'sd9173;
   localparam logic signed [DATA_BITS-1:0] RST_ORIGIN_RE = -32'sd10905190;
   localparam logic signed [DATA_BITS-1:0] RST_ORIGIN_IM = -32'sd4953473;
   localparam logic [LIMIT_BITS-1:0]       RST_ITER_LIMIT = 16'd50;

   // one mapped point waiting for the iteration engine
   typedef struct packed {
      logic signed [DATA_BITS-1:0] c_re;
      logic signed [DATA_BITS-1:0] c_im;
      logic [LIMIT_BITS-1:0]       limit;
   } point_type;

   function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_BITS-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[DATA_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/mbe_front.sv -----
// ----------------------------------------------------------------------------
// mbe_front: register file and pixel-to-point mapping
// Holds the CSRs, multiplies pixel indexes by the steps, adds the origin.
// ----------------------------------------------------------------------------
module mbe_front
   import mbe_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]      csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COORD_BITS-1:0]     req_col,
   input  logic [COORD_BITS-1:0]     req_row,
   output logic                      q_valid,
   input  logic                      q_ready,
   output point_type                 q_data
);

   localparam int PROD_W = DATA_BITS + COORD_BITS + 1;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [DATA_BITS-1:0] step_x_re_ff, step_x_re_in;
   logic signed [DATA_BITS-1:0] step_x_im_ff, step_x_im_in;
   logic signed [DATA_BITS-1:0] step_y_re_ff, step_y_re_in;
   logic signed [DATA_BITS-1:0] step_y_im_ff, step_y_im_in;
   logic signed [DATA_BITS-1:0] origin_re_ff, origin_re_in;
   logic signed [DATA_BITS-1:0] origin_im_ff, origin_im_in;
   logic [LIMIT_BITS-1:0]       limit_ff, limit_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0] p_xr_ff, p_xr_in, p_yr_ff, p_yr_in;
   logic signed [PROD_W-1:0] p_xi_ff, p_xi_in, p_yi_ff, p_yi_in;
   logic [LIMIT_BITS-1:0]    s1_limit_ff, s1_limit_in;

   logic signed [PROD_W-1:0] col_ext, row_ext;
   logic signed [SUM_W-1:0]  sum_re, sum_im;
   logic                     req_take;

   // CSR writes
   always_comb begin
      step_x_re_in = step_x_re_ff;
      step_x_im_in = step_x_im_ff;
      step_y_re_in = step_y_re_ff;
      step_y_im_in = step_y_im_ff;
      origin_re_in = origin_re_ff;
      origin_im_in = origin_im_ff;
      limit_in     = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STEP_X_RE:  step_x_re_in = csr_data;
            REG_STEP_X_IM:  step_x_im_in = csr_data;
            REG_STEP_Y_RE:  step_y_re_in = csr_data;
            REG_STEP_Y_IM:  step_y_im_in = csr_data;
            REG_ORIGIN_RE:  origin_re_in = csr_data;
            REG_ORIGIN_IM:  origin_im_in = csr_data;
            REG_ITER_LIMIT: limit_in     = csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_re_ff <= RST_STEP_X_RE;
         step_x_im_ff <= RST_STEP_X_IM;
         step_y_re_ff <= RST_STEP_Y_RE;
         step_y_im_ff <= RST_STEP_Y_IM;
         origin_re_ff <= RST_ORIGIN_RE;
         origin_im_ff <= RST_ORIGIN_IM;
         limit_ff     <= RST_ITER_LIMIT;
      end else begin
         step_x_re_ff <= step_x_re_in;
         step_x_im_ff <= step_x_im_in;
         step_y_re_ff <= step_y_re_in;
         step_y_im_ff <= step_y_im_in;
         origin_re_ff <= origin_re_in;
         origin_im_ff <= origin_im_in;
         limit_ff     <= limit_in;
      end
   end

   // stage 1: four step * index products
   assign req_ready = !s1_valid_ff || q_ready;
   assign req_take  = req_valid && req_ready;
   assign col_ext   = {{(PROD_W-COORD_BITS){1'b0}}, req_col};
   assign row_ext   = {{(PROD_W-COORD_BITS){1'b0}}, req_row};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      p_xr_in     = p_xr_ff;
      p_yr_in     = p_yr_ff;
      p_xi_in     = p_xi_ff;
      p_yi_in     = p_yi_ff;
      s1_limit_in = s1_limit_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         p_xr_in     = PROD_W'(step_x_re_ff) * col_ext;
         p_yr_in     = PROD_W'(step_y_re_ff) * row_ext;
         p_xi_in     = PROD_W'(step_x_im_ff) * col_ext;
         p_yi_in     = PROD_W'(step_y_im_ff) * row_ext;
         s1_limit_in = limit_ff;
      end else if (q_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      p_xr_ff     <= p_xr_in;
      p_yr_ff     <= p_yr_in;
      p_xi_ff     <= p_xi_in;
      p_yi_ff     <= p_yi_in;
      s1_limit_ff <= s1_limit_in;
   end

   // stage 2: add origin, clamp, push into the queue
   assign sum_re = SUM_W'(p_xr_ff) + SUM_W'(p_yr_ff) + SUM_W'(origin_re_ff);
   assign sum_im = SUM_W'(p_xi_ff) + SUM_W'(p_yi_ff) + SUM_W'(origin_im_ff);

   assign q_valid      = s1_valid_ff;
   assign q_data.c_re  = sat32(64'(sum_re));
   assign q_data.c_im  = sat32(64'(sum_im));
   assign q_data.limit = s1_limit_ff;

endmodule

// ----- hdl/mbe_queue.sv -----
// ----------------------------------------------------------------------------
// mbe_queue: small FIFO of mapped points
// Decouples the mapping front from the iteration engine.
// ----------------------------------------------------------------------------
module mbe_queue
   import mbe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  point_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output point_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   point_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mbe_engine.sv -----
// ----------------------------------------------------------------------------
// mbe_engine: z = z*z + c iteration and result register
// Each step: square products, then update and escape test.
// ----------------------------------------------------------------------------
module mbe_engine
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pt_valid,
   output logic                        pt_ready,
   input  point_type                   pt_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [COUNT_BITS-1:0]       rsp_count,
   output logic                        rsp_inside,
   output logic signed [DATA_BITS-1:0] rsp_re,
   output logic signed [DATA_BITS-1:0] rsp_im
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;

   // escape threshold on floor(|z|^2 / 2^F); out of reach above 55 fraction bits
   localparam bit          ESC_ON    = (FRAC_BITS <= 55);
   localparam logic [63:0] ESC_LIMIT = 64'd400 << FRAC_BITS;

   logic [1:0]                  state_ff, state_in;
   logic signed [DATA_BITS-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [DATA_BITS-1:0] z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [COUNT_BITS-1:0]       lim_ff, lim_in, n_ff, n_in;
   logic signed [63:0]          rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;

   logic                        out_valid_ff, out_valid_in;
   logic [COUNT_BITS-1:0]       out_count_ff, out_count_in;
   logic                        out_inside_ff, out_inside_in;
   logic signed [DATA_BITS-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;

   logic [63:0]                 mag_sq;
   logic                        escaped, finish, out_free;
   logic signed [DATA_BITS-1:0] next_re, next_im;

   assign mag_sq   = 64'(rr_ff) + 64'(ii_ff);
   assign escaped  = ESC_ON && ((mag_sq >> FRAC_BITS) >= ESC_LIMIT);
   assign next_re  = sat32(((rr_ff - ii_ff) >>> FRAC_BITS) + 64'(c_re_ff));
   assign next_im  = sat32((ri_ff >>> (FRAC_BITS - 1)) + 64'(c_im_ff));
   assign finish   = escaped || (n_ff == lim_ff);
   assign out_free = !out_valid_ff || rsp_ready;
   assign pt_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      c_re_in       = c_re_ff;
      c_im_in       = c_im_ff;
      z_re_in       = z_re_ff;
      z_im_in       = z_im_ff;
      lim_in        = lim_ff;
      n_in          = n_ff;
      rr_in         = rr_ff;
      ii_in         = ii_ff;
      ri_in         = ri_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_count_in  = out_count_ff;
      out_inside_in = out_inside_ff;
      out_re_in     = out_re_ff;
      out_im_in     = out_im_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pt_valid) begin
               c_re_in  = pt_data.c_re;
               c_im_in  = pt_data.c_im;
               lim_in   = COUNT_BITS'(pt_data.limit);
               z_re_in  = '0;
               z_im_in  = '0;
               n_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rr_in    = z_re_ff * z_re_ff;
            ii_in    = z_im_ff * z_im_ff;
            ri_in    = z_re_ff * z_im_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (finish) begin
               // hold here until the result register is free
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_count_in  = n_ff;
                  out_inside_in = !escaped;
                  out_re_in     = z_re_ff;
                  out_im_in     = z_im_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               z_re_in  = next_re;
               z_im_in  = next_im;
               n_in     = n_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      c_re_ff       <= c_re_in;
      c_im_ff       <= c_im_in;
      z_re_ff       <= z_re_in;
      z_im_ff       <= z_im_in;
      lim_ff        <= lim_in;
      n_ff          <= n_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      ri_ff         <= ri_in;
      out_count_ff  <= out_count_in;
      out_inside_ff <= out_inside_in;
      out_re_ff     <= out_re_in;
      out_im_ff     <= out_im_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_inside = out_inside_ff;
   assign rsp_re     = out_re_ff;
   assign rsp_im     = out_im_ff;

endmodule

// ----- hdl/mandelbrot_escape_iteration_core.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration_core: escape-time iteration per pixel
// Maps a pixel to c = step_x*col + step_y*row + origin, then runs
// z = z*z + c until |z|^2 >= 400 or the iteration limit is reached.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: pixel_col, pixel_row
//  rsp     | out | rsp_tvalid/tready    | tdata: iteration_count, final_re,
//          |     |                      |        final_im; tuser: inside_set
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
//  Flow: the front registers the step products, then adds the origin into a
//  2-entry queue; the engine takes a point, then runs rounds of squares, then
//  update and escape test, n+1 rounds for n steps.
//  Reset: synchronous, active high; clears handshake state, restores CSR defaults.
//  A held response parks the engine in its last round; the front and queue
//  keep taking requests until full.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration_core
   import mbe_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   localparam int IN_DATA_W  = ((2 * COORD_BITS) + 7) / 8 * 8,
   localparam int OUT_DATA_W = ((COUNT_BITS + 2 * DATA_BITS) + 7) / 8 * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [IN_DATA_W-1:0]      req_tdata,   // pixel_col, pixel_row
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_DATA_W-1:0]     rsp_tdata,   // iteration_count, final_re, final_im
   output logic                      rsp_tuser,   // inside_set
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]      csr_data
);

   point_type                   q_wr_data, q_rd_data;
   logic                        q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
   logic [COUNT_BITS-1:0]       res_count;
   logic signed [DATA_BITS-1:0] res_re, res_im;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   mbe_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_col   (req_tdata[COORD_BITS-1:0]),
      .req_row   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .q_valid   (q_wr_valid),
      .q_ready   (q_wr_ready),
      .q_data    (q_wr_data)
   );

   // queue between mapping and iteration
   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_wr_valid),
      .push_ready (q_wr_ready),
      .push_data  (q_wr_data),
      .pop_valid  (q_rd_valid),
      .pop_ready  (q_rd_ready),
      .pop_data   (q_rd_data)
   );

   mbe_engine #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .pt_valid   (q_rd_valid),
      .pt_ready   (q_rd_ready),
      .pt_data    (q_rd_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_count  (res_count),
      .rsp_inside (rsp_tuser),
      .rsp_re     (res_re),
      .rsp_im     (res_im)
   );

   // pack response, lowest field first, zero padded to whole bytes
   assign rsp_tdata = OUT_DATA_W'({res_im, res_re, res_count});

endmodule

// ----- hdl/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker: port-level assertions for the escape-time core
// Tracks the iteration limit and outstanding requests from the ports.
// ----------------------------------------------------------------------------
module mbe_checker
   import mbe_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   localparam int OUT_DATA_W = ((COUNT_BITS + 2 * DATA_BITS) + 7) / 8 * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [OUT_DATA_W-1:0]     rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [DATA_BITS-1:0]      csr_data
);

   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [7:0]            pending_ff, pending_in;
   logic                  req_fire, rsp_fire;
   logic [COUNT_BITS-1:0] lim, cnt;
   logic [DATA_BITS-1:0]  fin_re, fin_im;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign lim      = COUNT_BITS'(limit_ff);
   assign cnt      = rsp_tdata[COUNT_BITS-1:0];
   assign fin_re   = rsp_tdata[COUNT_BITS+DATA_BITS-1:COUNT_BITS];
   assign fin_im   = rsp_tdata[COUNT_BITS+2*DATA_BITS-1:COUNT_BITS+DATA_BITS];

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready && (csr_index == REG_ITER_LIMIT)) begin
         limit_in = csr_data[LIMIT_BITS-1:0];
      end
      pending_in = pending_ff + {7'd0, req_fire} - {7'd0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= RST_ITER_LIMIT;
         pending_ff <= '0;
      end else begin
         limit_ff   <= limit_in;
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("response without an outstanding request");

   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> cnt == lim)
      else $error("inside point did not run to the iteration limit");

   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> cnt != '0 && cnt <= lim)
      else $error("escape count out of range");

   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && cnt == '0 |-> fin_re == '0 && fin_im == '0)
      else $error("zero-step result with nonzero z");

endmodule

bind mandelbrot_escape_iteration_core mbe_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_mbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
